FILE: sv/mask_profile_tracer_top_macros.svh
// Assertion macros for the port-level checker file.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef MASK_PROFILE_TRACER_TOP_MACROS_SVH
`define MASK_PROFILE_TRACER_TOP_MACROS_SVH

// Same-cycle implication.
`define MPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/mpt_pkg.sv
// Shared constants for the mask profile tracer.
// Used by the top level, both checkers and the testbench.
`timescale 1ns / 1ps

package mpt_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int CFG_W   = 11;
	localparam int CFG_IDX_W = 2;
	localparam int HOFF_W  = 10;
	localparam int RADO_W  = 11;
	localparam int ARC_W   = 28;
	localparam int STAT_W  = 2;

	localparam logic [ARC_W-1:0] ARC_MAX = {ARC_W{1'b1}};
	localparam logic [7:0] WHITE_LEVEL = 8'd255;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_EDGES  = 2'd1;
	localparam logic [STAT_W-1:0] ST_ROW_EDGE  = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_READY = 2'd3;

	typedef logic [1:0] change_cnt_t;

endpackage

FILE: sv/mpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/mask_profile_tracer_top.sv
// Mask profile tracer top level.
// Depends on mpt_pkg and mpt_ram.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per item: cmd 0 is
//   a pixel in raster order, cmd 1 fetches the next traced point.
//   Output channel (out_valid/out_stall) carries one word per fetch and
//   nothing per pixel. The configuration port writes image_width (index 0)
//   or image_height (index 1) and restarts the frame. A fetch's word
//   passes the fetch stage and point RAM read registers, then the output
//   register. After the last pixel of a frame the profile builder runs
//   over the edge and point RAMs: a backward pass reads and evaluates each
//   row in the span, a forward pass reads and evaluates each row and writes
//   each kept point; kept points after the first get a bit-serial square
//   root. The input stalls throughout.
//   Reset: no points, status not ready, frame at row 0, column 0.
//   A stalled output word holds; a further fetch waits until the output
//   register is free, while pixels keep flowing.
`timescale 1ns / 1ps

module mask_profile_tracer_top #(
	parameter int MAX_WIDTH  = mpt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mpt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [mpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mpt_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [7:0]                       pixel_red,
	input  logic [7:0]                       pixel_green,
	input  logic [7:0]                       pixel_blue,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             point_valid,
	output logic [mpt_pkg::HOFF_W-1:0]       height_offset,
	output logic signed [mpt_pkg::RADO_W-1:0] radius_half,
	output logic [mpt_pkg::ARC_W-1:0]        arc_length,
	output logic                             last_point,
	output logic [mpt_pkg::STAT_W-1:0]       status
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int HW   = $clog2(MAX_HEIGHT);
	localparam int DW   = CW + 1;
	localparam int HDW  = HW + 1;
	localparam int RW   = CW + 2;
	localparam int DRW  = CW + 1;
	localparam int AW   = mpt_pkg::ARC_W;
	localparam int VWA  = 2 * HW + 16;
	localparam int VWB  = 2 * DRW + 14;
	localparam int VWR  = ((VWA > VWB) ? VWA : VWB) + 1;
	localparam int SQ_N = (VWR + 1) / 2;
	localparam int VW   = 2 * SQ_N;
	localparam int EW   = CW + 1;
	localparam int PW   = HW + RW + AW;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_B_RD   = 4'd1;
	localparam logic [3:0] S_B_EV   = 4'd2;
	localparam logic [3:0] S_F_RD0  = 4'd3;
	localparam logic [3:0] S_F_LD0  = 4'd4;
	localparam logic [3:0] S_F_RD   = 4'd5;
	localparam logic [3:0] S_F_EV   = 4'd6;
	localparam logic [3:0] S_SQ_MUL = 4'd7;
	localparam logic [3:0] S_SQ_SUM = 4'd8;
	localparam logic [3:0] S_SQ_IT  = 4'd9;
	localparam logic [3:0] S_F_WR   = 4'd10;

	logic [3:0] state_q;

	logic [mpt_pkg::CFG_W-1:0] width_cfg_q, height_cfg_q;
	logic [DW-1:0]  w_eff;
	logic [HDW-1:0] h_eff;
	logic [CW-1:0]  center;

	always_comb begin
		if (width_cfg_q == '0) begin
			w_eff = DW'(1);
		end else if (32'(width_cfg_q) > MAX_WIDTH) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = DW'(width_cfg_q);
		end
		if (height_cfg_q == '0) begin
			h_eff = HDW'(1);
		end else if (32'(height_cfg_q) > MAX_HEIGHT) begin
			h_eff = HDW'(MAX_HEIGHT);
		end else begin
			h_eff = HDW'(height_cfg_q);
		end
		center = CW'(w_eff >> 1);
	end

	// trace state
	logic [23:0] prev_color_q;
	logic        seen_q;
	logic [HW-1:0] start_q, end_q;
	mpt_pkg::change_cnt_t chg_q;
	logic [HW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] edge_q;
	logic          found_q;

	logic [HDW-1:0] count_q;
	logic [HDW-1:0] fidx_q;
	logic [mpt_pkg::STAT_W-1:0] stat_q;

	// builder state
	logic [HW-1:0] fin_start_q, nm1_q, bi_q, fi_q;
	logic signed [RW-1:0] rad_nx_q;
	logic grow_nx_q;
	logic signed [RW-1:0] prev_rad_q, cur_rad_q, last_rad_q, pend_rad_q;
	logic cur_grow_q, dir_q, done_q;
	logic [HW-1:0] last_h_q, pend_h_q;
	logic [HW-1:0] dh_q;
	logic [DRW-1:0] dr_q;
	logic [2*HW-1:0] dh2_q;
	logic [2*DRW-1:0] dr2_q;
	logic [VW-1:0] sq_v_q, sq_res_q, sq_bit_q;
	logic [AW-1:0] arc_q;
	logic [HDW-1:0] cnt_q;

	// fetch pipeline
	logic f_s1, pv_s1, last_s1;
	logic [mpt_pkg::STAT_W-1:0] st_s1;
	logic out_valid_q;

	// memories
	logic          e_we;
	logic [HW-1:0] e_waddr, e_raddr;
	logic [EW-1:0] e_wdata, e_rdata;
	logic          p_we;
	logic [HW-1:0] p_waddr, p_raddr;
	logic [PW-1:0] p_wdata, p_rdata;

	mpt_ram #(.WIDTH(EW), .DEPTH(MAX_HEIGHT)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	mpt_ram #(.WIDTH(PW), .DEPTH(MAX_HEIGHT)) u_point_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	// pixel path
	logic in_acc, px_acc, fe_acc;
	logic white, right_side, at_center, col_last, row_last;
	logic [23:0] color;
	logic [CW-1:0] edge_n;
	logic found_n;
	mpt_pkg::change_cnt_t chg_n;
	logic [HW-1:0] start_n, end_n;

	assign in_stall = (state_q != S_IDLE) ||
		((cmd == mpt_pkg::CMD_FETCH) && (out_valid_q || f_s1));
	assign in_acc = in_valid && !in_stall;
	assign px_acc = in_acc && (cmd == mpt_pkg::CMD_PIXEL);
	assign fe_acc = in_acc && (cmd == mpt_pkg::CMD_FETCH);

	always_comb begin
		color = {pixel_red, pixel_green, pixel_blue};
		white = (pixel_red == mpt_pkg::WHITE_LEVEL) && (pixel_green == mpt_pkg::WHITE_LEVEL)
			&& (pixel_blue == mpt_pkg::WHITE_LEVEL);
		right_side = col_q >= center;
		at_center = col_q == center;
		col_last = DW'(col_q) == w_eff - DW'(1);
		row_last = HDW'(row_q) == h_eff - HDW'(1);
		edge_n = (white && right_side) ? col_q : edge_q;
		found_n = ((col_q == '0) ? 1'b0 : found_q) | (white && right_side);
		chg_n = chg_q;
		start_n = start_q;
		end_n = end_q;
		if (at_center && chg_q < 2'd2 && seen_q && color != prev_color_q) begin
			if (chg_q == 2'd0) begin
				start_n = row_q;
				chg_n = 2'd1;
			end else begin
				end_n = row_q - HW'(1);
				chg_n = 2'd2;
			end
		end
	end

	// builder combinational helpers
	logic signed [RW-1:0] b_rad;
	logic b_grow;
	logic signed [RW-1:0] nx_rad;
	logic nx_grow;
	logic f_last, f_keep, f_flip;
	logic signed [RW:0] f_diff;
	logic [VW-1:0] sq_try;
	logic [AW:0] arc_sum;
	logic [AW-1:0] arc_n;

	always_comb begin
		b_rad = $signed({1'b0, e_rdata[CW-1:0], 1'b0}) - $signed({1'b0, w_eff});
		if (bi_q == nm1_q) begin
			b_grow = 1'b0;
		end else if (rad_nx_q > b_rad) begin
			b_grow = 1'b1;
		end else if (rad_nx_q < b_rad) begin
			b_grow = 1'b0;
		end else begin
			b_grow = grow_nx_q;
		end

		nx_rad = $signed(p_rdata[RW:1]);
		nx_grow = p_rdata[0];
		f_last = fi_q == nm1_q;
		f_flip = 1'b0;
		if (fi_q == '0 || f_last) begin
			f_keep = 1'b1;
		end else if (cur_rad_q == prev_rad_q) begin
			f_keep = (cur_rad_q != nx_rad) && (cur_grow_q != dir_q);
			f_flip = f_keep;
		end else begin
			f_keep = 1'b1;
		end
		f_diff = (RW+1)'(cur_rad_q) - (RW+1)'(last_rad_q);

		sq_try = sq_res_q + sq_bit_q;
		arc_sum = (AW+1)'(arc_q) + (AW+1)'(sq_res_q[SQ_N-1:0]);
		arc_n = arc_sum[AW] ? mpt_pkg::ARC_MAX : arc_sum[AW-1:0];
	end

	// memory ports
	always_comb begin
		e_we = px_acc && col_last;
		e_waddr = row_q;
		e_wdata = {found_n, edge_n};
		e_raddr = fin_start_q + bi_q;

		p_we = 1'b0;
		p_waddr = bi_q;
		p_wdata = PW'({rad_nx_q, 1'b0});
		unique case (state_q)
			S_B_EV: begin
				p_we = 1'b1;
				p_waddr = bi_q;
				p_wdata = PW'({b_rad, b_grow});
			end
			S_F_WR: begin
				p_we = 1'b1;
				p_waddr = cnt_q[HW-1:0];
				p_wdata = {pend_h_q, pend_rad_q, arc_n};
			end
			default: ;
		endcase

		unique case (state_q)
			S_F_RD0: p_raddr = '0;
			S_F_RD: p_raddr = fi_q + HW'(1);
			default: p_raddr = fidx_q[HW-1:0];
		endcase
	end

	// main control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_cfg_q <= mpt_pkg::CFG_W'(mpt_pkg::MAX_WIDTH_DEF);
			height_cfg_q <= mpt_pkg::CFG_W'(mpt_pkg::MAX_HEIGHT_DEF);
			prev_color_q <= '0;
			seen_q <= 1'b0;
			start_q <= '0;
			end_q <= '0;
			chg_q <= '0;
			row_q <= '0;
			col_q <= '0;
			found_q <= 1'b0;
			count_q <= '0;
			fidx_q <= '0;
			stat_q <= mpt_pkg::ST_NOT_READY;
			cnt_q <= '0;
			done_q <= 1'b0;
			f_s1 <= 1'b0;
		end else begin
			f_s1 <= fe_acc;
			if (cfg_wen && (cfg_index == mpt_pkg::REG_WIDTH ||
				cfg_index == mpt_pkg::REG_HEIGHT)) begin
				if (cfg_index == mpt_pkg::REG_WIDTH) begin
					width_cfg_q <= cfg_wdata;
				end else begin
					height_cfg_q <= cfg_wdata;
				end
				prev_color_q <= '0;
				seen_q <= 1'b0;
				start_q <= '0;
				end_q <= '0;
				chg_q <= '0;
				row_q <= '0;
				col_q <= '0;
				count_q <= '0;
				fidx_q <= '0;
				stat_q <= mpt_pkg::ST_NOT_READY;
			end
			if (fe_acc && stat_q == mpt_pkg::ST_OK && fidx_q < count_q) begin
				fidx_q <= fidx_q + HDW'(1);
			end
			if (px_acc) begin
				found_q <= found_n;
				chg_q <= chg_n;
				start_q <= start_n;
				end_q <= end_n;
				if (at_center && chg_q < 2'd2) begin
					prev_color_q <= color;
					seen_q <= 1'b1;
				end
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						row_q <= '0;
						prev_color_q <= '0;
						seen_q <= 1'b0;
						start_q <= '0;
						end_q <= '0;
						chg_q <= '0;
						fidx_q <= '0;
						count_q <= '0;
						if (chg_n < 2'd2) begin
							stat_q <= mpt_pkg::ST_NO_EDGES;
						end else begin
							state_q <= S_B_RD;
						end
					end else begin
						row_q <= row_q + HW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: ;
				S_B_RD: state_q <= S_B_EV;
				S_B_EV: begin
					if (!e_rdata[CW]) begin
						stat_q <= mpt_pkg::ST_ROW_EDGE;
						state_q <= S_IDLE;
					end else if (bi_q == '0) begin
						state_q <= S_F_RD0;
					end else begin
						state_q <= S_B_RD;
					end
				end
				S_F_RD0: state_q <= S_F_LD0;
				S_F_LD0: begin
					cnt_q <= '0;
					state_q <= S_F_RD;
				end
				S_F_RD: state_q <= S_F_EV;
				S_F_EV: begin
					done_q <= f_last;
					if (f_keep) begin
						state_q <= (cnt_q == '0) ? S_F_WR : S_SQ_MUL;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_SQ_MUL: state_q <= S_SQ_SUM;
				S_SQ_SUM: state_q <= S_SQ_IT;
				S_SQ_IT: begin
					if (sq_bit_q[0]) begin
						state_q <= S_F_WR;
					end
				end
				S_F_WR: begin
					cnt_q <= cnt_q + HDW'(1);
					if (done_q) begin
						count_q <= cnt_q + HDW'(1);
						stat_q <= mpt_pkg::ST_OK;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_F_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (px_acc) begin
			edge_q <= edge_n;
			if (col_last && row_last) begin
				fin_start_q <= start_n;
				nm1_q <= end_n - start_n;
				bi_q <= end_n - start_n;
			end
		end
		unique case (state_q)
			S_B_EV: begin
				rad_nx_q <= b_rad;
				grow_nx_q <= b_grow;
				bi_q <= bi_q - HW'(1);
			end
			S_F_LD0: begin
				cur_rad_q <= nx_rad;
				cur_grow_q <= nx_grow;
				dir_q <= nx_grow;
				prev_rad_q <= nx_rad;
				fi_q <= '0;
				arc_q <= '0;
			end
			S_F_EV: begin
				if (f_keep && !(fi_q == '0 || f_last)) begin
					dir_q <= f_flip ? !dir_q : cur_grow_q;
				end
				pend_h_q <= fi_q;
				pend_rad_q <= cur_rad_q;
				dh_q <= fi_q - last_h_q;
				dr_q <= DRW'(f_diff[RW] ? -f_diff : f_diff);
				sq_res_q <= '0;
				prev_rad_q <= cur_rad_q;
				cur_rad_q <= nx_rad;
				cur_grow_q <= nx_grow;
				fi_q <= fi_q + HW'(1);
			end
			S_SQ_MUL: begin
				dh2_q <= dh_q * dh_q;
				dr2_q <= dr_q * dr_q;
			end
			S_SQ_SUM: begin
				sq_v_q <= (VW'(dh2_q) << 16) + (VW'(dr2_q) << 14);
				sq_res_q <= '0;
				sq_bit_q <= VW'(1) << (VW - 2);
			end
			S_SQ_IT: begin
				if (sq_v_q >= sq_try) begin
					sq_v_q <= sq_v_q - sq_try;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			S_F_WR: begin
				arc_q <= arc_n;
				last_h_q <= pend_h_q;
				last_rad_q <= pend_rad_q;
			end
			default: ;
		endcase
		if (fe_acc) begin
			st_s1 <= stat_q;
			pv_s1 <= (stat_q == mpt_pkg::ST_OK) && (fidx_q < count_q);
			last_s1 <= (fidx_q + HDW'(1)) == count_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (f_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (f_s1) begin
			point_valid <= pv_s1;
			status <= st_s1;
			last_point <= pv_s1 && last_s1;
			height_offset <= pv_s1 ? mpt_pkg::HOFF_W'(p_rdata[PW-1 -: HW]) : '0;
			radius_half <= pv_s1 ?
				mpt_pkg::RADO_W'($signed(p_rdata[AW +: RW])) : '0;
			arc_length <= pv_s1 ? p_rdata[AW-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/mpt_checker.sv
// Port-level checker for the mask profile tracer, bound to the top level.
// Depends on mpt_pkg and mask_profile_tracer_top_macros.svh.
`timescale 1ns / 1ps
`include "mask_profile_tracer_top_macros.svh"

module mpt_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_wen,
	input logic [mpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input logic [mpt_pkg::CFG_W-1:0]        cfg_wdata,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             cmd,
	input logic [7:0]                       pixel_red,
	input logic [7:0]                       pixel_green,
	input logic [7:0]                       pixel_blue,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             point_valid,
	input logic [mpt_pkg::HOFF_W-1:0]       height_offset,
	input logic signed [mpt_pkg::RADO_W-1:0] radius_half,
	input logic [mpt_pkg::ARC_W-1:0]        arc_length,
	input logic                             last_point,
	input logic [mpt_pkg::STAT_W-1:0]       status
);

	`MPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(arc_length) && $stable(height_offset), "stalled output word changed")

	`MPT_ASSERT_NOW(a_err_no_point, out_valid && status != mpt_pkg::ST_OK, !point_valid && height_offset == '0 && arc_length == '0, "error word carries a point")

	`MPT_ASSERT_NOW(a_empty_zero, out_valid && !point_valid, radius_half == '0 && last_point == 1'b0 && arc_length == '0, "empty word has nonzero fields")

endmodule

bind mask_profile_tracer_top mpt_checker u_mpt_checker (.*);

FILE: sim/mpt_profile_checker.sv
`timescale 1ns / 1ps
// Checker for the mask profile tracer: watches the config port and both
// word channels, predicts every fetch result and compares it.
// Depends on mpt_pkg.

module mpt_profile_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [mpt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mpt_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              cmd,
	input  logic [7:0]                        pixel_red,
	input  logic [7:0]                        pixel_green,
	input  logic [7:0]                        pixel_blue,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              point_valid,
	input  logic [mpt_pkg::HOFF_W-1:0]        height_offset,
	input  logic signed [mpt_pkg::RADO_W-1:0] radius_half,
	input  logic [mpt_pkg::ARC_W-1:0]         arc_length,
	input  logic                              last_point,
	input  logic [mpt_pkg::STAT_W-1:0]        status,
	output int                                errors,
	output int                                pending,
	output int                                words_seen,
	output int                                results_seen,
	output int                                points_seen
);
	import mpt_pkg::*;

	localparam int MAXW = MAX_WIDTH_DEF;
	localparam int MAXH = MAX_HEIGHT_DEF;

	typedef struct packed {
		logic                     pv;
		logic [HOFF_W-1:0]        hoff;
		logic signed [RADO_W-1:0] rad;
		logic [ARC_W-1:0]         arc;
		logic                     last;
		logic [STAT_W-1:0]        st;
	} point_word_t;

	point_word_t expected_points[$];

	logic [CFG_W-1:0] width_reg, height_reg;
	logic [23:0] prev_color;
	bit center_seen;
	int start_row, end_row, changes, row_cnt, col_cnt;
	int edge_col[MAXH];
	bit edge_found[MAXH];
	int pt_h[MAXH];
	int pt_r[MAXH];
	longint unsigned pt_arc[MAXH];
	int pt_count, fetch_idx;
	logic [STAT_W-1:0] frame_st;
	int rad_tmp[MAXH];
	bit grow_tmp[MAXH];

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int m);
		if (v == 0) return 1;
		return (int'(v) > m) ? m : int'(v);
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else
				res >>= 1;
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void clear_trace();
		prev_color = 0; center_seen = 0;
		start_row = 0; end_row = 0; changes = 0;
		row_cnt = 0; col_cnt = 0;
	endfunction

	function automatic void build_profile(input int w);
		int n, i, k, cnt, drs;
		bit cur, keep;
		longint unsigned arc, dh, dr;
		fetch_idx = 0;
		pt_count = 0;
		if (changes < 2) begin
			frame_st = ST_NO_EDGES;
			return;
		end
		n = end_row - start_row + 1;
		for (i = 0; i < n; i++) begin
			if (!edge_found[start_row + i]) begin
				frame_st = ST_ROW_EDGE;
				return;
			end
			rad_tmp[i] = 2 * edge_col[start_row + i] - w;
		end
		grow_tmp[n-1] = 0;
		for (i = n - 1; i > 0; i--) begin
			k = i - 1;
			if (rad_tmp[i] > rad_tmp[k]) grow_tmp[k] = 1;
			else if (rad_tmp[i] < rad_tmp[k]) grow_tmp[k] = 0;
			else grow_tmp[k] = grow_tmp[i];
		end
		if (n > 1) grow_tmp[n-1] = grow_tmp[n-2];
		cur = grow_tmp[0];
		cnt = 0;
		for (i = 0; i < n; i++) begin
			keep = 0;
			if (i == 0 || i == n - 1) keep = 1;
			else if (rad_tmp[i] == rad_tmp[i-1]) begin
				if (rad_tmp[i] != rad_tmp[i+1] && grow_tmp[i] != cur) begin
					cur = !cur;
					keep = 1;
				end
			end else begin
				cur = grow_tmp[i];
				keep = 1;
			end
			if (keep) begin
				pt_h[cnt] = i;
				pt_r[cnt] = rad_tmp[i];
				cnt++;
			end
		end
		arc = 0;
		pt_arc[0] = 0;
		for (i = 1; i < cnt; i++) begin
			dh = pt_h[i] - pt_h[i-1];
			drs = pt_r[i] - pt_r[i-1];
			dr = (drs < 0) ? -drs : drs;
			arc += floor_sqrt(dh * dh * 65536 + dr * dr * 16384);
			if (arc > ARC_MAX) arc = ARC_MAX;
			pt_arc[i] = arc;
		end
		pt_count = cnt;
		frame_st = ST_OK;
	endfunction

	function automatic void trace_pixel(input logic [7:0] r, g, b);
		int w, h, center, row, col;
		logic [23:0] color;
		w = clamp_dim(width_reg, MAXW);
		h = clamp_dim(height_reg, MAXH);
		color = {r, g, b};
		center = w / 2;
		row = row_cnt;
		col = col_cnt;
		if (row >= h || col >= w) begin
			row = 0;
			col = 0;
		end
		if (col == 0) edge_found[row] = 0;
		if (col == center && changes < 2) begin
			if (center_seen && color != prev_color) begin
				if (changes == 0) begin
					start_row = row;
					changes = 1;
				end else begin
					end_row = row - 1;
					changes = 2;
				end
			end
			prev_color = color;
			center_seen = 1;
		end
		if (col >= center && r == WHITE_LEVEL && g == WHITE_LEVEL && b == WHITE_LEVEL) begin
			edge_col[row] = col;
			edge_found[row] = 1;
		end
		col++;
		if (col >= w) begin
			col = 0;
			row++;
			if (row >= h) begin
				build_profile(w);
				clear_trace();
				row = 0;
			end
		end
		row_cnt = row;
		col_cnt = col;
	endfunction

	function automatic point_word_t fetch_point();
		point_word_t p;
		p = '0;
		if (frame_st != ST_OK) begin
			p.st = frame_st;
			return p;
		end
		if (fetch_idx < pt_count) begin
			p.pv = 1;
			p.hoff = pt_h[fetch_idx];
			p.rad = pt_r[fetch_idx];
			p.arc = pt_arc[fetch_idx];
			p.last = (fetch_idx + 1 == pt_count);
			fetch_idx++;
		end
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_word_t want;
		if (!arst_n) begin
			width_reg = 11'd1024;
			height_reg = 11'd1024;
			clear_trace();
			pt_count = 0;
			fetch_idx = 0;
			frame_st = ST_NOT_READY;
			expected_points.delete();
			pending = 0;
		end else begin
			if (cfg_wen && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
				if (cfg_index == REG_WIDTH) width_reg = cfg_wdata;
				else height_reg = cfg_wdata;
				clear_trace();
				pt_count = 0;
				fetch_idx = 0;
				frame_st = ST_NOT_READY;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_points.size() == 0)
					report("result word with nothing expected");
				else begin
					want = expected_points.pop_front();
					if (point_valid !== want.pv)
						report($sformatf("point_valid %0b want %0b", point_valid, want.pv));
					if (height_offset !== want.hoff)
						report($sformatf("height_offset %0d want %0d", height_offset, want.hoff));
					if (radius_half !== want.rad)
						report($sformatf("radius_half %0d want %0d", radius_half, want.rad));
					if (arc_length !== want.arc)
						report($sformatf("arc_length %0d want %0d", arc_length, want.arc));
					if (last_point !== want.last)
						report($sformatf("last_point %0b want %0b", last_point, want.last));
					if (status !== want.st)
						report($sformatf("status %0d want %0d", status, want.st));
					if (want.pv) points_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				words_seen++;
				if (cmd == CMD_FETCH) expected_points.push_back(fetch_point());
				else trace_pixel(pixel_red, pixel_green, pixel_blue);
			end
			pending = expected_points.size();
		end
	end

	initial begin
		errors = 0;
		pending = 0;
		words_seen = 0;
		results_seen = 0;
		points_seen = 0;
	end

endmodule

FILE: sim/mask_profile_tracer_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the mask profile tracer: clock, reset, config writes,
// mask frames and fetches, receiver stalls and the verdict.
// Depends on mpt_pkg, mask_profile_tracer_top and mpt_profile_checker.

module mask_profile_tracer_top_tb;
	import mpt_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wen = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_stall;
	logic cmd = CMD_PIXEL;
	logic [7:0] pixel_red = 0, pixel_green = 0, pixel_blue = 0;
	logic out_valid;
	logic out_stall = 0;
	logic point_valid, last_point;
	logic [HOFF_W-1:0] height_offset;
	logic signed [RADO_W-1:0] radius_half;
	logic [ARC_W-1:0] arc_length;
	logic [STAT_W-1:0] status;

	int errors, pending, words_seen, results_seen, points_seen;
	int cycles = 0;
	int burst_left = 0;
	int gap_max = 6;
	int random_words = 0;
	bit counting = 0;
	bit hold_req = 0;
	int cur_w = 1024, cur_h = 1024;
	int frames_sent = 0;

	always #5 clk = ~clk;

	mask_profile_tracer_top uut (.*);

	mpt_profile_checker checker_i (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall patterns, with an occasional long hold-off
	initial begin
		int mode, left, ph;
		mode = 0;
		left = 0;
		ph = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (500) @(negedge clk);
				hold_req = 0;
				out_stall <= 0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 300);
				end
				left--;
				ph++;
				case (mode)
					0: out_stall <= 0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= (ph % 5 < 2);
					default: out_stall <= ($urandom_range(0, 9) < 8);
				endcase
			end
		end
	end

	task automatic send_word(input logic c, input logic [23:0] px);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				@(negedge clk) in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1;
		cmd <= c;
		{pixel_red, pixel_green, pixel_blue} <= px;
		do @(posedge clk); while (in_stall);
		burst_left--;
		if (counting) random_words++;
	endtask

	function automatic logic [23:0] dark_pixel();
		logic [23:0] v;
		v = $urandom;
		if (v == 24'hFFFFFF) v[0] = 0;
		return v;
	endfunction

	task automatic fetches(input int n);
		repeat (n) send_word(CMD_FETCH, $urandom);
	endtask

	// kind 0: random noise, 1: mask with sparse noise, else clean mask
	task automatic send_frame(input int kind, input bit mid_fetch);
		int w, h, c, s, e, ed, r, col;
		logic [23:0] bg_a, bg_b, px;
		w = (cur_w == 0) ? 1 : (cur_w > 1024 ? 1024 : cur_w);
		h = (cur_h == 0) ? 1 : (cur_h > 1024 ? 1024 : cur_h);
		c = w / 2;
		s = $urandom_range(1, (h > 2) ? h - 2 : 1);
		e = $urandom_range(s, (h - 2 > s) ? h - 2 : s);
		bg_a = dark_pixel();
		bg_b = dark_pixel();
		ed = $urandom_range(c, w - 1);
		for (r = 0; r < h; r++) begin
			case ($urandom_range(0, 3))
				2: ed += $urandom_range(0, 2);
				3: ed -= $urandom_range(0, 2);
				default: ;
			endcase
			if (ed < c) ed = c;
			if (ed > w - 1) ed = w - 1;
			for (col = 0; col < w; col++) begin
				if (kind == 0 || (kind == 1 && $urandom_range(0, 19) == 0))
					px = $urandom;
				else if (col < c)
					px = $urandom;
				else if (r >= s && r <= e)
					px = (col <= ed) ? 24'hFFFFFF : dark_pixel();
				else if (col == c)
					px = (r < s) ? bg_a : bg_b;
				else
					px = dark_pixel();
				if (mid_fetch && $urandom_range(0, 40) == 0) send_word(CMD_FETCH, $urandom);
				send_word(CMD_PIXEL, px);
			end
		end
		frames_sent++;
	endtask

	task automatic drain();
		@(negedge clk) in_valid <= 0;
		burst_left = 0;
		wait (pending == 0);
		repeat (60 * ((cur_h == 0) ? 1 : (cur_h > 1024 ? 1024 : cur_h)) + 300)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		drain();
		@(negedge clk);
		cfg_wen <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk) cfg_wen <= 0;
		if (idx == REG_WIDTH) cur_w = val;
		else if (idx == REG_HEIGHT) cur_h = val;
	endtask

	task automatic set_size(input int w, input int h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	initial begin
		int kinds;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: not-ready fetch, tiny frame, fetch past the end
		send_word(CMD_FETCH, 24'h000000);
		set_size(3, 5);
		send_frame(2, 0);
		fetches(5);
		send_word(CMD_FETCH, 24'hFFFFFF);

		// extremes of both registers and an unused index
		set_size(0, 0);
		send_frame(0, 0);
		fetches(2);
		set_size(2047, 1);
		send_frame(2, 0);
		fetches(2);
		set_size(1, 2047);
		send_frame(2, 0);
		fetches(4);
		write_reg(REG_HEIGHT, 1024);
		write_reg(REG_WIDTH, 1);
		write_reg(2'd3, 7);
		fetches(2);

		counting = 1;
		while (random_words < 1900) begin
			set_size($urandom_range(1, 16), $urandom_range(2, 24));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
			kinds = $urandom_range(1, 3);
			repeat (kinds) begin
				send_frame(($urandom_range(0, 9) == 0) ? 0 : (($urandom_range(0, 3) == 0) ? 1 : 2),
					$urandom_range(0, 1));
				fetches($urandom_range(1, cur_h + 3));
			end
			if (frames_sent > 20 && !hold_req && $urandom_range(0, 7) == 0) begin
				hold_req = 1;
				fetches(30);
			end
		end

		@(negedge clk) in_valid <= 0;
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("run covered %0d input words in %0d frames, %0d results, %0d points",
			words_seen, frames_sent, results_seen, points_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
